FILE: hw/rtl/mvc_pkg.sv
// ----------------------------------------------------------------------------
// Mirrored-volume controller package
// Shared types, codes and helper functions for the controller and its engine.
// ----------------------------------------------------------------------------
package mvc_pkg;

  // Field widths fixed by the interface.
  localparam int ADDR_W   = 32;
  localparam int OFFSET_W = 16;
  localparam int HEALTH_W = 8;
  localparam int DEV_W    = 3;
  localparam int CNT_W    = 4;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_DEVICE_COUNT  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_USABLE_BLOCKS = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_BLOCK_OFFSET  = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_INIT_HEALTH   = 2'd3;

  // Input item kinds.
  localparam logic [1:0] KIND_READ     = 2'd0;
  localparam logic [1:0] KIND_WRITE    = 2'd1;
  localparam logic [1:0] KIND_RESPONSE = 2'd2;
  localparam logic [1:0] KIND_START    = 2'd3;

  // Result item kinds.
  localparam logic [1:0] OUT_READ_CMD   = 2'd0;
  localparam logic [1:0] OUT_WRITE_CMD  = 2'd1;
  localparam logic [1:0] OUT_REQ_DONE   = 2'd2;
  localparam logic [1:0] OUT_START_DONE = 2'd3;

  // Completion status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FAULT = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [1:0] {
    VOL_OPTIMAL  = 2'd0,
    VOL_DEGRADED = 2'd1,
    VOL_FAULTY   = 2'd2
  } vol_state_t;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Configuration as seen by the engine, member count already limited.
  typedef struct packed {
    logic [CNT_W-1:0]    member_total;
    logic [ADDR_W-1:0]   usable_blocks;
    logic [OFFSET_W-1:0] block_offset;
    logic [HEALTH_W-1:0] init_health;
  } cfg_t;

  // One result item plus its valid flag.
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [DEV_W-1:0]  dev;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
    vol_state_t        vstate;
  } result_t;

  typedef struct packed {
    logic             found;
    logic [DEV_W-1:0] idx;
  } pick_t;

  // Lowest healthy member at or above from and below total.
  function automatic pick_t first_healthy(input logic [HEALTH_W-1:0] health,
                                          input logic [CNT_W-1:0] total,
                                          input logic [CNT_W-1:0] from);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = HEALTH_W - 1; i >= 0; i--) begin
      if (health[i] && (CNT_W'(i) >= from) && (CNT_W'(i) < total)) begin
        p.found = 1'b1;
        p.idx   = DEV_W'(i);
      end
    end
    return p;
  endfunction

  // Number of set bits in a health mask.
  function automatic logic [CNT_W-1:0] count_members(input logic [HEALTH_W-1:0] health);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < HEALTH_W; i++) begin
      c = c + CNT_W'(health[i]);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/mvc_engine.sv
// ----------------------------------------------------------------------------
// Mirrored-volume controller engine
// Holds the volume state and works out the result of one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module mvc_engine #(
  parameter int MEMBERS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic [1:0]              kind,
  input  logic [mvc_pkg::ADDR_W-1:0] addr,
  input  logic                    ok,
  input  mvc_pkg::cfg_t           cfg,
  output mvc_pkg::result_t        res
);

  mvc_pkg::vol_state_t           cond_r, cond_nxt;
  logic [MEMBERS-1:0]            health_r;
  logic [mvc_pkg::HEALTH_W-1:0]  health_nxt;
  mvc_pkg::op_t                  op_r, op_nxt;
  logic [mvc_pkg::DEV_W-1:0]     cur_r, cur_nxt;
  logic [mvc_pkg::CNT_W-1:0]     succ_r, succ_nxt;
  logic [mvc_pkg::ADDR_W-1:0]    target_r, target_nxt;

  logic [mvc_pkg::HEALTH_W-1:0]  health_ext;
  logic [mvc_pkg::HEALTH_W-1:0]  health_cleared;
  logic [mvc_pkg::HEALTH_W-1:0]  rsp_health;
  logic [mvc_pkg::HEALTH_W:0]    start_mask;
  logic [mvc_pkg::HEALTH_W-1:0]  start_health;
  logic [mvc_pkg::CNT_W-1:0]     start_cnt;
  logic [mvc_pkg::CNT_W-1:0]     succ_inc;
  logic [mvc_pkg::ADDR_W-1:0]    phys;
  logic                          in_range;
  mvc_pkg::pick_t                pick_req;
  mvc_pkg::pick_t                pick_rsp;

  // Health bits widened to the full member range; absent members read as failed.
  always_comb begin
    health_ext = '0;
    health_ext[MEMBERS-1:0] = health_r;
  end

  // Shared decision terms.
  assign health_cleared = health_ext & ~(mvc_pkg::HEALTH_W'(1) << cur_r);
  assign rsp_health     = ok ? health_ext : health_cleared;
  assign start_mask     = (9'd1 << cfg.member_total) - 9'd1;
  assign start_health   = cfg.init_health & start_mask[mvc_pkg::HEALTH_W-1:0];
  assign start_cnt      = mvc_pkg::count_members(start_health);
  assign succ_inc       = succ_r + mvc_pkg::CNT_W'(ok);
  assign phys           = addr + {{(mvc_pkg::ADDR_W-mvc_pkg::OFFSET_W){1'b0}},
                                  cfg.block_offset};
  assign in_range       = addr < cfg.usable_blocks;
  assign pick_req = mvc_pkg::first_healthy(health_ext, cfg.member_total, '0);
  assign pick_rsp = mvc_pkg::first_healthy(rsp_health, cfg.member_total,
                                           {1'b0, cur_r} + 4'd1);

  // Next state of the volume and of the pending operation.
  always_comb begin
    cond_nxt   = cond_r;
    health_nxt = health_ext;
    op_nxt     = op_r;
    cur_nxt    = cur_r;
    succ_nxt   = succ_r;
    target_nxt = target_r;
    if (fire) begin
      case (kind)
        mvc_pkg::KIND_START: begin
          health_nxt = start_health;
          op_nxt     = mvc_pkg::OP_IDLE;
          if (start_cnt == '0) begin
            cond_nxt = mvc_pkg::VOL_FAULTY;
          end else if (start_cnt < cfg.member_total) begin
            cond_nxt = mvc_pkg::VOL_DEGRADED;
          end else begin
            cond_nxt = mvc_pkg::VOL_OPTIMAL;
          end
        end
        mvc_pkg::KIND_RESPONSE: begin
          case (op_r)
            mvc_pkg::OP_READ: begin
              if (ok) begin
                op_nxt = mvc_pkg::OP_IDLE;
              end else begin
                health_nxt = health_cleared;
                if (pick_rsp.found) begin
                  cur_nxt = pick_rsp.idx;
                end else begin
                  op_nxt   = mvc_pkg::OP_IDLE;
                  cond_nxt = mvc_pkg::VOL_FAULTY;
                end
              end
            end
            mvc_pkg::OP_WRITE: begin
              succ_nxt   = succ_inc;
              health_nxt = rsp_health;
              if (pick_rsp.found) begin
                cur_nxt = pick_rsp.idx;
              end else begin
                op_nxt = mvc_pkg::OP_IDLE;
                if (succ_inc == '0) begin
                  cond_nxt = mvc_pkg::VOL_FAULTY;
                end else if (succ_inc < cfg.member_total) begin
                  cond_nxt = mvc_pkg::VOL_DEGRADED;
                end
              end
            end
            default: begin
              // A response with nothing outstanding is dropped.
            end
          endcase
        end
        default: begin
          // Read or write request on an idle, usable volume.
          if (op_r == mvc_pkg::OP_IDLE && cond_r != mvc_pkg::VOL_FAULTY && in_range) begin
            target_nxt = phys;
            succ_nxt   = '0;
            if (pick_req.found) begin
              op_nxt  = (kind == mvc_pkg::KIND_READ) ? mvc_pkg::OP_READ : mvc_pkg::OP_WRITE;
              cur_nxt = pick_req.idx;
            end else begin
              cond_nxt = mvc_pkg::VOL_FAULTY;
            end
          end
        end
      endcase
    end
  end

  // Result item for the current input.
  always_comb begin
    res.valid  = 1'b0;
    res.kind   = mvc_pkg::OUT_REQ_DONE;
    res.dev    = '0;
    res.addr   = '0;
    res.status = mvc_pkg::STATUS_OK;
    res.vstate = cond_nxt;
    if (fire) begin
      case (kind)
        mvc_pkg::KIND_START: begin
          res.valid  = 1'b1;
          res.kind   = mvc_pkg::OUT_START_DONE;
          res.status = (start_cnt == '0) ? mvc_pkg::STATUS_FAULT : mvc_pkg::STATUS_OK;
        end
        mvc_pkg::KIND_RESPONSE: begin
          if (op_r != mvc_pkg::OP_IDLE) begin
            res.valid = 1'b1;
            if (op_nxt != mvc_pkg::OP_IDLE) begin
              res.kind = (op_nxt == mvc_pkg::OP_READ) ? mvc_pkg::OUT_READ_CMD
                                                      : mvc_pkg::OUT_WRITE_CMD;
              res.dev  = cur_nxt;
              res.addr = target_nxt;
            end else begin
              res.status = (cond_nxt == mvc_pkg::VOL_FAULTY) ? mvc_pkg::STATUS_FAULT
                                                             : mvc_pkg::STATUS_OK;
            end
          end
        end
        default: begin
          res.valid = 1'b1;
          if (op_r != mvc_pkg::OP_IDLE || cond_r == mvc_pkg::VOL_FAULTY) begin
            res.status = mvc_pkg::STATUS_FAULT;
          end else if (!in_range) begin
            res.status = mvc_pkg::STATUS_RANGE;
          end else if (pick_req.found) begin
            res.kind = (op_nxt == mvc_pkg::OP_READ) ? mvc_pkg::OUT_READ_CMD
                                                    : mvc_pkg::OUT_WRITE_CMD;
            res.dev  = cur_nxt;
            res.addr = target_nxt;
          end else begin
            res.status = mvc_pkg::STATUS_FAULT;
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cond_r   <= mvc_pkg::VOL_FAULTY;
      health_r <= '0;
      op_r     <= mvc_pkg::OP_IDLE;
      cur_r    <= '0;
      succ_r   <= '0;
      target_r <= '0;
    end else begin
      cond_r   <= cond_nxt;
      health_r <= health_nxt[MEMBERS-1:0];
      op_r     <= op_nxt;
      cur_r    <= cur_nxt;
      succ_r   <= succ_nxt;
      target_r <= target_nxt;
    end
  end

  // The member with a command outstanding is still marked healthy.
  a_cur_healthy: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r != mvc_pkg::OP_IDLE) |-> health_ext[cur_r])
    else $error("outstanding command addresses an unhealthy member");

  // Issuing a device command leaves an operation pending.
  a_cmd_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.valid && (res.kind == mvc_pkg::OUT_READ_CMD ||
                           res.kind == mvc_pkg::OUT_WRITE_CMD))
    |=> (op_r != mvc_pkg::OP_IDLE))
    else $error("device command issued without a pending operation");

  // Starting the volume aborts any pending operation.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && kind == mvc_pkg::KIND_START) |=> (op_r == mvc_pkg::OP_IDLE))
    else $error("operation still pending after start");

  // A successful start never leaves the volume faulty.
  a_start_grade: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.valid && res.kind == mvc_pkg::OUT_START_DONE &&
     res.status == mvc_pkg::STATUS_OK) |=> (cond_r != mvc_pkg::VOL_FAULTY))
    else $error("volume faulty after a successful start");

  // Write successes cannot exceed HEALTH_W, the largest number of members.
  a_succ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    succ_r <= mvc_pkg::CNT_W'(mvc_pkg::HEALTH_W))
    else $error("write success count out of range");

endmodule

FILE: hw/rtl/mirror_volume_controller_unit.sv
// ----------------------------------------------------------------------------
// Mirrored-volume controller
// Top level: stream ports, configuration registers and result register.
// ----------------------------------------------------------------------------
// The controller takes one item every clock cycle while it is not stalled. An
// accepted item is held in the input register and its result is then written
// to the result register, from which it is taken. Throughput is set by the
// single-pass decision logic of the engine (a priority pick over the health
// bits, a 32-bit range compare and the offset add), so the input side only
// stalls while the result register is full and not being taken. A device
// response arriving with no command outstanding gives no result. There is no
// clearing pass after reset.
module mirror_volume_controller_unit #(
  parameter int MAX_DEVICES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // block_address [31:0], response_ok [32], zeros above
  input  logic [1:0]  in_tuser,   // kind [1:0]
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // device_index [2:0], physical_address [34:3],
                                  // status [36:35], volume_state [38:37], zero [39]
  output logic [1:0]  out_tuser,  // out_kind [1:0]
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int MEMBERS = (MAX_DEVICES > mvc_pkg::HEALTH_W) ? mvc_pkg::HEALTH_W
                                                               : MAX_DEVICES;

  logic [mvc_pkg::CNT_W-1:0]    dev_count_r;
  logic [mvc_pkg::ADDR_W-1:0]   usable_r;
  logic [mvc_pkg::OFFSET_W-1:0] offset_r;
  logic [mvc_pkg::HEALTH_W-1:0] init_health_r;

  logic                         s1_valid_r;
  logic [1:0]                   s1_kind_r;
  logic [mvc_pkg::ADDR_W-1:0]   s1_addr_r;
  logic                         s1_ok_r;
  logic                         s1_advance;

  logic                         out_valid_r;
  logic [1:0]                   out_kind_r;
  logic [mvc_pkg::DEV_W-1:0]    out_dev_r;
  logic [mvc_pkg::ADDR_W-1:0]   out_addr_r;
  logic [1:0]                   out_status_r;
  logic [1:0]                   out_vstate_r;

  mvc_pkg::cfg_t                cfg;
  mvc_pkg::result_t             res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r   <= 4'd2;
      usable_r      <= '0;
      offset_r      <= '0;
      init_health_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        mvc_pkg::REG_DEVICE_COUNT:  dev_count_r   <= cfg_wdata[mvc_pkg::CNT_W-1:0];
        mvc_pkg::REG_USABLE_BLOCKS: usable_r      <= cfg_wdata[mvc_pkg::ADDR_W-1:0];
        mvc_pkg::REG_BLOCK_OFFSET:  offset_r      <= cfg_wdata[mvc_pkg::OFFSET_W-1:0];
        mvc_pkg::REG_INIT_HEALTH:   init_health_r <= cfg_wdata[mvc_pkg::HEALTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Member count limited to the members this build supports.
  assign cfg.member_total  = (dev_count_r > mvc_pkg::CNT_W'(MEMBERS))
                             ? mvc_pkg::CNT_W'(MEMBERS) : dev_count_r;
  assign cfg.usable_blocks = usable_r;
  assign cfg.block_offset  = offset_r;
  assign cfg.init_health   = init_health_r;

  // Input register; it moves on whenever the result register can take a result.
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_addr_r <= in_tdata[mvc_pkg::ADDR_W-1:0];
      s1_ok_r   <= in_tdata[mvc_pkg::ADDR_W];
    end
  end

  mvc_engine #(
    .MEMBERS (MEMBERS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_advance),
    .kind  (s1_kind_r),
    .addr  (s1_addr_r),
    .ok    (s1_ok_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_kind_r   <= res.kind;
      out_dev_r    <= res.dev;
      out_addr_r   <= res.addr;
      out_status_r <= res.status;
      out_vstate_r <= res.vstate;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_vstate_r, out_status_r, out_addr_r, out_dev_r};

endmodule
